/* design/dsfp_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dsfp_pkg
// Types and codes shared by the direct sound FIFO pair.
// ---------------------------------------------------------------------------
package dsfp_pkg;

    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_TIMER = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [1:0] REG_SOUND_ENABLE = 2'd0;
    localparam logic [1:0] REG_TIMER_FOR_A  = 2'd1;
    localparam logic [1:0] REG_TIMER_FOR_B  = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        fifo_sel;
        logic [31:0] push_word;
        logic        overflow_timer;
    } t_req;

    typedef struct packed {
        logic signed [7:0] latch_a;
        logic signed [7:0] latch_b;
        logic [5:0]        fill_a;
        logic [5:0]        fill_b;
        logic              request_a;
        logic              request_b;
    } t_res;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_fifo_ctl;

endpackage

/* design/dsfp_fifo.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dsfp_fifo
// One byte FIFO held in a synchronous memory, with its head, fill count and
// output sample latch.
// ---------------------------------------------------------------------------
module dsfp_fifo #(
    parameter int DEPTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dsfp_pkg::t_fifo_ctl          i_ctl,
    input  logic [7:0]                   i_wdata,
    output logic [7:0]                   o_latch,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    import dsfp_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rdata;
    logic [AW-1:0] r_head;
    logic [AW-1:0] n_head;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [7:0]    r_latch;
    logic [7:0]    n_latch;
    logic [AW:0]   tail_sum;
    logic [AW-1:0] tail;
    logic          wr_en;

    assign tail_sum = (AW + 1)'(r_head) + (AW + 1)'(r_count);
    assign tail     = (tail_sum >= (AW + 1)'(DEPTH)) ?
                      AW'(tail_sum - (AW + 1)'(DEPTH)) : AW'(tail_sum);
    assign wr_en    = i_ctl.push && (r_count < CW'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[tail] <= i_wdata;
        end
        r_rdata <= r_mem[r_head];
    end

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_latch = r_latch;
        if (i_ctl.clear) begin
            n_head  = '0;
            n_count = '0;
        end else if (wr_en) begin
            n_count = r_count + CW'(1);
        end else if (i_ctl.pop && (r_count != '0)) begin
            n_latch = r_rdata;
            n_count = r_count - CW'(1);
            n_head  = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_latch <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_latch <= n_latch;
        end
    end

    assign o_latch = r_latch;
    assign o_count = r_count;

endmodule

/* design/direct_sound_fifo_pair_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// direct_sound_fifo_pair_unit
// Two sample FIFOs drained by timer overflows into output latches.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake                Payload
// request   in         start high, busy low     i_req (t_req)
// result    out        o_done strobe, 1 cycle   o_res (t_res)
// config    in         APB write access phase   paddr, pwdata
//
// A push writes its four bytes one at a time through the single write port
// in S_PUSH, then returns its result in S_RESP. A timer overflow with sound
// enabled passes through S_POP, where the latches take the registered read
// of the head entry, then S_RESP; clear, other requests and a timer overflow
// with sound disabled go straight to S_RESP. Busy stays high through the
// result cycle, so the next transaction can be accepted in the cycle after.
// Reset is synchronous and empties both FIFOs and zeroes the latches.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ---------------------------------------------------------------------------
module direct_sound_fifo_pair_unit #(
    parameter int FIFO_DEPTH   = 32,
    parameter int REFILL_LEVEL = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  dsfp_pkg::t_req i_req,
    output logic           o_done,
    output dsfp_pkg::t_res o_res,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import dsfp_pkg::*;

    localparam int CW = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PUSH = 4'b0010,
        S_POP  = 4'b0100,
        S_RESP = 4'b1000
    } t_state;

    t_state      r_state;
    t_state      n_state;
    logic [1:0]  r_kind;
    logic        r_sel;
    logic [31:0] r_word;
    logic [1:0]  r_idx;
    logic        r_drain_a;
    logic        r_drain_b;
    logic        r_sound_enable;
    logic        r_timer_for_a;
    logic        r_timer_for_b;
    logic        accept;
    logic        cfg_wr;
    logic        run;
    t_fifo_ctl   ctl_a;
    t_fifo_ctl   ctl_b;
    logic [7:0]  wbyte;
    logic [7:0]  latch_a;
    logic [7:0]  latch_b;
    logic [CW-1:0] count_a;
    logic [CW-1:0] count_b;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign run    = r_sound_enable && (i_req.req_type == REQ_TIMER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sound_enable <= 1'b0;
            r_timer_for_a  <= 1'b0;
            r_timer_for_b  <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_SOUND_ENABLE: r_sound_enable <= pwdata[0];
                REG_TIMER_FOR_A:  r_timer_for_a  <= pwdata[0];
                REG_TIMER_FOR_B:  r_timer_for_b  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SOUND_ENABLE: prdata = {31'd0, r_sound_enable};
            REG_TIMER_FOR_A:  prdata = {31'd0, r_timer_for_a};
            REG_TIMER_FOR_B:  prdata = {31'd0, r_timer_for_b};
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req.req_type == REQ_PUSH) begin
                        n_state = S_PUSH;
                    end else if (run) begin
                        n_state = S_POP;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_PUSH: begin
                if (r_idx == 2'd3) begin
                    n_state = S_RESP;
                end
            end
            S_POP:   n_state = S_RESP;
            S_RESP:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_drain_a <= 1'b0;
            r_drain_b <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_idx     <= '0;
                r_drain_a <= run && (i_req.overflow_timer == r_timer_for_a);
                r_drain_b <= run && (i_req.overflow_timer == r_timer_for_b);
            end else if (r_state == S_PUSH) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_req.req_type;
            r_sel  <= i_req.fifo_sel;
            r_word <= i_req.push_word;
        end
    end

    assign wbyte = r_word[{r_idx, 3'b000} +: 8];

    always_comb begin
        ctl_a.push  = (r_state == S_PUSH) && !r_sel;
        ctl_a.pop   = (r_state == S_POP) && r_drain_a;
        ctl_a.clear = accept && (i_req.req_type == REQ_CLEAR) && !i_req.fifo_sel;
        ctl_b.push  = (r_state == S_PUSH) && r_sel;
        ctl_b.pop   = (r_state == S_POP) && r_drain_b;
        ctl_b.clear = accept && (i_req.req_type == REQ_CLEAR) && i_req.fifo_sel;
    end

    dsfp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_a),
        .i_wdata (wbyte),
        .o_latch (latch_a),
        .o_count (count_a)
    );

    dsfp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_b),
        .i_wdata (wbyte),
        .o_latch (latch_b),
        .o_count (count_b)
    );

    assign o_done = (r_state == S_RESP);

    always_comb begin
        o_res.latch_a   = $signed(latch_a);
        o_res.latch_b   = $signed(latch_b);
        o_res.fill_a    = 6'(count_a);
        o_res.fill_b    = 6'(count_b);
        o_res.request_a = r_drain_a && (32'(count_a) <= REFILL_LEVEL);
        o_res.request_b = r_drain_b && (32'(count_b) <= REFILL_LEVEL);
    end

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) || $past(accept)))
        else $error("result strobe without a transaction in progress");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted transaction did not raise busy");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(count_a) <= FIFO_DEPTH) && (32'(count_b) <= FIFO_DEPTH))
        else $error("FIFO fill count beyond depth");

    a_request_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_res.request_a || o_res.request_b)) |-> (r_kind == REQ_TIMER))
        else $error("refill request on a transaction that is not a timer overflow");

endmodule
